@@ src/assert_macros.svh @@
// Shared assertion macros: clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CLQ_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concurrency limit queue check failed");

// Next-cycle implication.
`define CLQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concurrency limit queue check failed");

`endif

@@ src/clq_pkg.sv @@
package clq_pkg;

    localparam int WAIT_DEPTH  = 16;
    localparam int TAG_BITS    = 16;
    localparam int LIMIT_BITS  = 8;
    localparam int MAX_RESULTS = 16;

    localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int REL_W = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] MODE_POST   = 2'd0;
    localparam logic [1:0] MODE_DONE   = 2'd1;
    localparam logic [1:0] MODE_LIMIT  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [TAG_BITS-1:0]   request_tag;
        logic [LIMIT_BITS-1:0] new_limit;
    } in_item_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] forwarded_tag;
        logic                dropped;
        logic                last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_POST,
        CMD_DONE,
        CMD_LIMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [TAG_BITS-1:0]   tag;
        logic [LIMIT_BITS-1:0] limit;
    } cmd_t;

endpackage

@@ src/clq_front.sv @@
`include "assert_macros.svh"

module clq_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  clq_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output clq_pkg::cmd_t     cmd_data
);

    localparam int Q_DEPTH = 2;
    localparam int IDX_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    clq_pkg::cmd_t     q_reg [Q_DEPTH];
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [IDX_W-1:0]  tail;

    clq_pkg::cmd_t cmd_in;
    logic          cmd_in_ok;
    logic          push;
    logic          pop;

    // Classify the incoming transaction; the unused mode is swallowed here.
    always_comb
    begin
        cmd_in.tag   = in_data.request_tag;
        cmd_in.limit = in_data.new_limit;
        cmd_in.kind  = clq_pkg::CMD_POST;
        cmd_in_ok    = 1'b1;
        unique case (in_data.mode)
            clq_pkg::MODE_POST:   cmd_in.kind = clq_pkg::CMD_POST;
            clq_pkg::MODE_DONE:   cmd_in.kind = clq_pkg::CMD_DONE;
            clq_pkg::MODE_LIMIT:  cmd_in.kind = clq_pkg::CMD_LIMIT;
            clq_pkg::MODE_UNUSED: cmd_in_ok   = 1'b0;
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_data  = q_reg[head_reg];

    assign push = in_valid && in_ready && cmd_in_ok;
    assign pop  = cmd_valid && cmd_ready;
    assign tail = IDX_W'(head_reg + IDX_W'(count_reg));

    always_comb
    begin
        head_next  = pop ? IDX_W'(head_reg + 1'b1) : head_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail] <= cmd_in;
        end
    end

    `CLQ_ASSERT(a_q_bound, 1'b1, count_reg <= QCNT_W'(Q_DEPTH))
    `CLQ_ASSERT_NEXT(a_unused_mode, in_valid && in_ready && in_data.mode == clq_pkg::MODE_UNUSED && !pop, $stable(count_reg))

endmodule

@@ src/clq_back.sv @@
`include "assert_macros.svh"

module clq_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  clq_pkg::cmd_t      cmd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output clq_pkg::out_item_t out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REL,
        S_EMIT
    } state_t;

    localparam int PTR_W = clq_pkg::PTR_W;
    localparam int CNT_W = clq_pkg::CNT_W;
    localparam int REL_W = clq_pkg::REL_W;
    localparam int ACT_W = clq_pkg::LIMIT_BITS;
    localparam int TAG_W = clq_pkg::TAG_BITS;

    state_t state_reg, state_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] waiting_count_reg, waiting_count_next;
    logic [ACT_W-1:0] active_count_reg, active_count_next;
    logic [ACT_W-1:0] active_limit_reg, active_limit_next;
    logic [REL_W-1:0] rel_cnt_reg, rel_cnt_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    clq_pkg::out_item_t out_data_reg, out_data_next;

    logic [TAG_W-1:0] wait_mem [clq_pkg::WAIT_DEPTH];
    logic [TAG_W-1:0] rd_data_reg;

    logic             can_load;
    logic             wr_en;
    logic             rd_en;
    logic             more;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign can_load   = !out_valid_reg || out_ready;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(clq_pkg::WAIT_DEPTH - 1)) ?
                        '0 : PTR_W'(rd_ptr_reg + 1'b1);
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(clq_pkg::WAIT_DEPTH - 1)) ?
                        '0 : PTR_W'(wr_ptr_reg + 1'b1);

    // Whether the limit loop will release another tag after this one.
    assign more = (ACT_W'(active_count_reg + 1'b1) < active_limit_reg)
               && (waiting_count_reg != CNT_W'(1))
               && (REL_W'(rel_cnt_reg + 1'b1) < REL_W'(clq_pkg::MAX_RESULTS));

    always_comb
    begin
        state_next         = state_reg;
        rd_ptr_next        = rd_ptr_reg;
        wr_ptr_next        = wr_ptr_reg;
        waiting_count_next = waiting_count_reg;
        active_count_next  = active_count_reg;
        active_limit_next  = active_limit_reg;
        rel_cnt_next       = rel_cnt_reg;
        last_next          = last_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_data_next      = out_data_reg;
        cmd_ready          = 1'b0;
        wr_en              = 1'b0;
        rd_en              = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_data.kind)
                        clq_pkg::CMD_POST:
                        begin
                            priority if (active_count_reg < active_limit_reg)
                            begin
                                if (can_load)
                                begin
                                    cmd_ready         = 1'b1;
                                    active_count_next = ACT_W'(active_count_reg + 1'b1);
                                    out_valid_next    = 1'b1;
                                    out_data_next     = '{cmd_data.tag, 1'b0, 1'b1};
                                end
                            end
                            else if (waiting_count_reg < CNT_W'(clq_pkg::WAIT_DEPTH))
                            begin
                                cmd_ready          = 1'b1;
                                wr_en              = 1'b1;
                                wr_ptr_next        = wr_ptr_inc;
                                waiting_count_next = CNT_W'(waiting_count_reg + 1'b1);
                            end
                            else if (can_load)
                            begin
                                // Reject: wait store is full.
                                cmd_ready      = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '{cmd_data.tag, 1'b1, 1'b1};
                            end
                        end
                        clq_pkg::CMD_DONE:
                        begin
                            cmd_ready = 1'b1;
                            if (waiting_count_reg != '0)
                            begin
                                // Hand the slot to the oldest waiting tag.
                                rd_en              = 1'b1;
                                rd_ptr_next        = rd_ptr_inc;
                                waiting_count_next = CNT_W'(waiting_count_reg - 1'b1);
                                last_next          = 1'b1;
                                state_next         = S_EMIT;
                            end
                            else if (active_count_reg != '0)
                            begin
                                active_count_next = ACT_W'(active_count_reg - 1'b1);
                            end
                        end
                        clq_pkg::CMD_LIMIT:
                        begin
                            cmd_ready         = 1'b1;
                            active_limit_next = cmd_data.limit;
                            rel_cnt_next      = '0;
                            state_next        = S_REL;
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            S_REL:
            begin
                if (active_count_reg < active_limit_reg && waiting_count_reg != '0
                    && rel_cnt_reg < REL_W'(clq_pkg::MAX_RESULTS))
                begin
                    rd_en              = 1'b1;
                    rd_ptr_next        = rd_ptr_inc;
                    waiting_count_next = CNT_W'(waiting_count_reg - 1'b1);
                    active_count_next  = ACT_W'(active_count_reg + 1'b1);
                    rel_cnt_next       = REL_W'(rel_cnt_reg + 1'b1);
                    last_next          = !more;
                    state_next         = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{rd_data_reg, 1'b0, last_reg};
                    state_next     = last_reg ? S_IDLE : S_REL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            waiting_count_reg <= '0;
            active_count_reg  <= '0;
            active_limit_reg  <= ACT_W'(1);
            rel_cnt_reg       <= '0;
            last_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            rd_ptr_reg        <= rd_ptr_next;
            wr_ptr_reg        <= wr_ptr_next;
            waiting_count_reg <= waiting_count_next;
            active_count_reg  <= active_count_next;
            active_limit_reg  <= active_limit_next;
            rel_cnt_reg       <= rel_cnt_next;
            last_reg          <= last_next;
            out_valid_reg     <= out_valid_next;
            out_data_reg      <= out_data_next;
        end
    end

    // Wait store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wait_mem[wr_ptr_reg] <= cmd_data.tag;
        end
        if (rd_en)
        begin
            rd_data_reg <= wait_mem[rd_ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CLQ_ASSERT(a_wait_bound, 1'b1, waiting_count_reg <= CNT_W'(clq_pkg::WAIT_DEPTH))
    `CLQ_ASSERT(a_empty_ptrs, waiting_count_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `CLQ_ASSERT(a_rel_bound, 1'b1, rel_cnt_reg <= REL_W'(clq_pkg::MAX_RESULTS))

endmodule

@@ src/concurrency_limit_queue_core.sv @@
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   clq_pkg::in_item_t   (mode, request_tag, new_limit)
// out      output     out_valid/out_ready clq_pkg::out_item_t  (forwarded_tag, dropped, last)
//
// A post is forwarded, queued or rejected straight from the idle state of the back end.
// A completion that pops a waiting tag goes through S_EMIT: the wait store read is registered.
// A limit change releases N waiting tags (N at most 16), each through S_REL and then S_EMIT.
// A two-entry command queue accepts input while the back end works or out stalls, until it is full.
// Reset clears counters and sets the limit to one; the wait store is not cleared.
module concurrency_limit_queue_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  clq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output clq_pkg::out_item_t out_data
);

    logic          cmd_valid;
    logic          cmd_ready;
    clq_pkg::cmd_t cmd_data;

    clq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    clq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ tb/clq_gate_checker.sv @@
module clq_gate_checker
    import clq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        mismatches,
    output int        pending_results
);

    logic [TAG_BITS-1:0]   wait_tags [WAIT_DEPTH];
    logic [PTR_W-1:0]      head;
    logic [PTR_W-1:0]      tail;
    logic [CNT_W-1:0]      n_waiting;
    logic [LIMIT_BITS-1:0] n_active;
    logic [LIMIT_BITS-1:0] cap;
    out_item_t             release_q [$];
    out_item_t             oldest;
    int                    fail_total = 0;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
        return PTR_W'((int'(slot) + 1) % WAIT_DEPTH);
    endfunction

    function automatic logic [TAG_BITS-1:0] take_oldest();
        logic [TAG_BITS-1:0] tag;
        tag       = wait_tags[head];
        head      = next_slot(head);
        n_waiting = n_waiting - 1'b1;
        return tag;
    endfunction

    // Work out the releases caused by one input transaction.
    function automatic void admit_item(input in_item_t it);
        out_item_t batch [$];
        case (it.mode)
            MODE_POST:
            begin
                if (n_active < cap)
                begin
                    n_active = n_active + 1'b1;
                    batch.push_back('{forwarded_tag: it.request_tag, dropped: 1'b0, last: 1'b0});
                end
                else if (n_waiting < WAIT_DEPTH)
                begin
                    wait_tags[tail] = it.request_tag;
                    tail            = next_slot(tail);
                    n_waiting       = n_waiting + 1'b1;
                end
                else
                begin
                    batch.push_back('{forwarded_tag: it.request_tag, dropped: 1'b1, last: 1'b0});
                end
            end
            MODE_DONE:
            begin
                // hand the slot to the oldest waiter, else free it
                if (n_waiting != 0)
                    batch.push_back('{forwarded_tag: take_oldest(), dropped: 1'b0, last: 1'b0});
                else if (n_active != 0)
                    n_active = n_active - 1'b1;
            end
            MODE_LIMIT:
            begin
                cap = it.new_limit;
                while (n_active < cap && n_waiting != 0 && batch.size() < MAX_RESULTS)
                begin
                    n_active = n_active + 1'b1;
                    batch.push_back('{forwarded_tag: take_oldest(), dropped: 1'b0, last: 1'b0});
                end
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            release_q.push_back(batch[k]);
    endfunction

    function automatic void note_failure(input string what);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t: %s", $realtime, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head      = '0;
            tail      = '0;
            n_waiting = '0;
            n_active  = '0;
            cap       = LIMIT_BITS'(1);
            release_q.delete();
            pending_results <= 0;
            mismatches      <= fail_total;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (release_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: tag %h dropped %b last %b",
                                           out_data.forwarded_tag, out_data.dropped,
                                           out_data.last));
                end
                else
                begin
                    oldest = release_q.pop_front();
                    if (out_data.forwarded_tag !== oldest.forwarded_tag ||
                        out_data.dropped !== oldest.dropped ||
                        out_data.last !== oldest.last)
                        note_failure($sformatf({"result mismatch: expected tag %h dropped %b",
                                                " last %b, got tag %h dropped %b last %b"},
                                               oldest.forwarded_tag, oldest.dropped,
                                               oldest.last, out_data.forwarded_tag,
                                               out_data.dropped, out_data.last));
                end
            end
            if (in_valid && in_ready)
                admit_item(in_data);
            pending_results <= release_q.size();
            mismatches      <= fail_total;
        end
    end

endmodule

@@ tb/concurrency_limit_queue_core_tb.sv @@
module concurrency_limit_queue_core_tb;
    import clq_pkg::*;

    localparam int RANDOM_ITEMS = 405;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 48;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int errors;
    int results_due;
    int cycle_count = 0;
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    concurrency_limit_queue_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    clq_gate_checker u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatches      (errors),
        .pending_results (results_due)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL concurrency_limit_queue_core");
            $finish;
        end
    end

    function automatic in_item_t build(input logic [1:0] mode, input logic [15:0] tag,
                                       input logic [7:0] lim);
        in_item_t it;
        it.mode        = mode;
        it.request_tag = tag;
        it.new_limit   = lim;
        return it;
    endfunction

    // Hold valid and payload until the transaction is taken.
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int         i;
        int         roll;
        int         post_pct;
        logic [1:0] mode;
        logic [7:0] lim;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        post_pct = 50;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one forwarded, one queued, unused mode ignored
        send_item(build(MODE_POST, 16'h0000, 8'h00));
        send_item(build(MODE_POST, 16'hFFFF, 8'hFF));
        send_item(build(MODE_UNUSED, 16'hFFFF, 8'hFF));
        // lowered limit: nothing revoked, completion still pops above the limit
        send_item(build(MODE_LIMIT, 16'hFFFF, 8'h00));
        send_item(build(MODE_DONE, 16'h0000, 8'hFF));
        // drain the count, then complete once more at zero
        send_item(build(MODE_DONE, 16'hFFFF, 8'h00));
        send_item(build(MODE_DONE, 16'h0000, 8'h00));
        // fill the wait queue, then overflow it
        for (i = 0; i < WAIT_DEPTH + 1; i++)
            send_item(build(MODE_POST, 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255))));
        // widest limit releases a full burst
        send_item(build(MODE_LIMIT, 16'h0000, 8'hFF));

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                post_pct = $urandom_range(30, 70);
            if (i == 350)
                idle_on = 1'b0;
            if (i == 100)
            begin
                // open the gate wide, then back up the result side
                send_item(build(MODE_LIMIT, 16'($urandom_range(0, 65535)), 8'hFF));
                hold_req = 1'b1;
            end
            if (i == 250)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (results_due != 0)
                    @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            if (i >= 100 && i < 125)
                mode = MODE_POST;
            else if (roll < post_pct)
                mode = MODE_POST;
            else if (roll < 90)
                mode = MODE_DONE;
            else if (roll < 98)
                mode = MODE_LIMIT;
            else
                mode = MODE_UNUSED;
            if ($urandom_range(0, 3) == 0)
                lim = 8'($urandom_range(0, 255));
            else
                lim = 8'($urandom_range(0, 4));
            send_item(build(mode, 16'($urandom_range(0, 65535)), lim));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && results_due == 0)
            $display("PASS concurrency_limit_queue_core");
        else
            $display("FAIL concurrency_limit_queue_core");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/clq_pkg.sv
src/clq_front.sv
src/clq_back.sv
src/concurrency_limit_queue_core.sv
tb/clq_gate_checker.sv
tb/concurrency_limit_queue_core_tb.sv
